// ===== rtl/spi_ctl_pkg.sv =====
// ----------------------------------------------------------------------------
// spi_ctl_pkg
// Shared types, register indexes, command codes and limits of the SPI
// controller.
// ----------------------------------------------------------------------------
package spi_ctl_pkg;

    // default upper limit of the word length
    localparam int DEF_MAX_WORD_BITS = 16;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int DATA_W  = 16;
    localparam int BPW_W   = 5;
    localparam int DIV_W   = 8;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 8;

    // divider limits
    localparam logic [DIV_W-1:0] DIV_MIN = 8'd6;
    localparam logic [DIV_W-1:0] DIV_MAX = 8'd254;

    // shortest word
    localparam logic [BPW_W-1:0] BPW_MIN = 5'd8;

    // register reset values
    localparam logic [BPW_W-1:0] BPW_RESET = 5'd8;
    localparam logic [DIV_W-1:0] DIV_RESET = 8'd254;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_MASTER_MODE      = 8'd0;
    localparam logic [CIDX_W-1:0] REG_CLOCK_PHASE      = 8'd1;
    localparam logic [CIDX_W-1:0] REG_CLOCK_POLARITY   = 8'd2;
    localparam logic [CIDX_W-1:0] REG_LSB_FIRST        = 8'd3;
    localparam logic [CIDX_W-1:0] REG_BITS_PER_WORD    = 8'd4;
    localparam logic [CIDX_W-1:0] REG_CLOCK_DIVIDER    = 8'd5;
    localparam logic [CIDX_W-1:0] REG_INTERRUPT_ENABLE = 8'd6;

    // bus commands
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STATUS = 2'd3;

    // configuration registers
    typedef struct packed {
        logic             master_mode;
        logic             clock_phase;
        logic             clock_polarity;
        logic             lsb_first;
        logic [BPW_W-1:0] bits_per_word;
        logic [DIV_W-1:0] clock_divider;
        logic             interrupt_enable;
    } cfg_t;

    // one peripheral clock tick
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] write_word;
        logic              miso_in;
        logic              mosi_in;
        logic              sclk_in;
        logic              select_n_in;
    } item_t;

    // pin and status levels after one tick
    typedef struct packed {
        logic              sclk_out;
        logic              mosi_out;
        logic              miso_out;
        logic [DATA_W-1:0] read_word;
        logic              transfer_done;
        logic              write_collision;
        logic              interrupt_request;
    } result_t;

endpackage

// ===== rtl/spi_ctl_engine.sv =====
// ----------------------------------------------------------------------------
// spi_ctl_engine
// Shift engine, clock divider and status flags. Advances one peripheral
// clock tick per step and presents the resulting pin and status levels.
// ----------------------------------------------------------------------------
module spi_ctl_engine
    import spi_ctl_pkg::*;
#(
    parameter int MAX_WORD_BITS = DEF_MAX_WORD_BITS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    abort,
    input  logic    step,
    input  item_t   item,
    output result_t res
);

    localparam int W  = MAX_WORD_BITS;
    localparam int CW = $clog2(MAX_WORD_BITS + 1);
    localparam int IW = $clog2(MAX_WORD_BITS);

    // engine state
    logic [W-1:0]     shift_reg, shift_next;
    logic [W-1:0]     recv_reg, recv_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic             lvl_reg, lvl_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             coll_reg, coll_next;
    logic             swr_reg, swr_next;
    logic             last_reg, last_next;
    logic             latch_reg, latch_next;

    // word length clamped to 8..MAX_WORD_BITS
    logic [CW-1:0]    wbits;
    logic [IW-1:0]    top_idx;
    logic [W-1:0]     wmask;
    logic [DIV_W-1:0] half;
    logic [DATA_W-1:0] rd;

    // shift one bit in, masked to the word length
    function automatic logic [W-1:0] shift_fn(input logic [W-1:0] sw,
                                              input logic lat,
                                              input logic lsb,
                                              input logic [IW-1:0] ti,
                                              input logic [W-1:0] msk);
        logic [W-1:0] r;
        if (lsb) begin
            r = (sw >> 1) | (W'(lat) << ti);
        end else begin
            r = (sw << 1) | W'(lat);
        end
        return r & msk;
    endfunction

    // word length, top bit index and mask
    always_comb begin
        if (cfg.bits_per_word < BPW_MIN) begin
            wbits = CW'(BPW_MIN);
        end else if (int'(cfg.bits_per_word) > MAX_WORD_BITS) begin
            wbits = CW'(MAX_WORD_BITS);
        end else begin
            wbits = CW'(cfg.bits_per_word);
        end
        top_idx = IW'(wbits - 1'b1);
        for (int i = 0; i < W; i++) begin
            wmask[i] = (i < int'(wbits));
        end
    end

    // half serial clock period from the clamped, even divider
    always_comb begin
        logic [DIV_W-1:0] d;
        logic [DIV_W:0]   e;
        if (cfg.clock_divider < DIV_MIN) begin
            d = DIV_MIN;
        end else if (cfg.clock_divider > DIV_MAX) begin
            d = DIV_MAX;
        end else begin
            d = cfg.clock_divider;
        end
        e    = {1'b0, d} + 1'b1;
        half = e[DIV_W:1];
    end

    // one tick of the controller
    always_comb begin
        logic edge_hit;
        logic edge_lead;
        logic din;

        shift_next = shift_reg;
        recv_next  = recv_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        lvl_next   = lvl_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        coll_next  = coll_reg;
        swr_next   = swr_reg;
        last_next  = last_reg;
        latch_next = latch_reg;
        rd         = '0;
        edge_hit   = 1'b0;
        edge_lead  = 1'b0;
        din        = 1'b0;

        if (abort) begin
            busy_next = 1'b0;
            cnt_next  = '0;
            div_next  = '0;
            lvl_next  = 1'b0;
        end

        if (step) begin
            // a status read followed by a data access clears the flags
            if ((item.cmd == CMD_WRITE || item.cmd == CMD_READ) && swr_reg) begin
                done_next = 1'b0;
                coll_next = 1'b0;
                swr_next  = 1'b0;
            end

            // bus access
            case (item.cmd)
                CMD_READ: begin
                    rd = DATA_W'(recv_reg);
                end
                CMD_STATUS: begin
                    swr_next = 1'b1;
                end
                CMD_WRITE: begin
                    if (busy_reg) begin
                        coll_next = 1'b1;
                    end else begin
                        shift_next = W'(item.write_word) & wmask;
                        if (cfg.master_mode) begin
                            cnt_next  = '0;
                            div_next  = '0;
                            lvl_next  = 1'b0;
                            busy_next = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            // serial clock source
            if (cfg.master_mode) begin
                if (busy_next) begin
                    div_next = div_next + 1'b1;
                    if (div_next >= half) begin
                        div_next  = '0;
                        lvl_next  = ~lvl_next;
                        edge_hit  = 1'b1;
                        edge_lead = lvl_next;
                        din       = item.miso_in;
                    end
                end
            end else if (!item.select_n_in) begin
                if (item.sclk_in != last_reg) begin
                    busy_next = 1'b1;
                    edge_hit  = 1'b1;
                    edge_lead = item.sclk_in ^ cfg.clock_polarity;
                    din       = item.mosi_in;
                end
            end else if (busy_next) begin
                busy_next = 1'b0;
                cnt_next  = '0;
                div_next  = '0;
                lvl_next  = 1'b0;
            end
            last_next = item.sclk_in;

            // sample and shift on serial clock edges
            if (edge_hit) begin
                if (edge_lead) begin
                    if (!cfg.clock_phase) begin
                        latch_next = din;
                    end else if (cnt_next != '0) begin
                        shift_next = shift_fn(shift_next, latch_next, cfg.lsb_first,
                                              top_idx, wmask);
                    end
                end else begin
                    if (!cfg.clock_phase) begin
                        shift_next = shift_fn(shift_next, latch_next, cfg.lsb_first,
                                              top_idx, wmask);
                    end else begin
                        latch_next = din;
                    end
                    cnt_next = cnt_next + 1'b1;
                    if (cnt_next >= wbits) begin
                        if (cfg.clock_phase) begin
                            shift_next = shift_fn(shift_next, latch_next, cfg.lsb_first,
                                                  top_idx, wmask);
                        end
                        recv_next = shift_next & wmask;
                        done_next = 1'b1;
                        busy_next = 1'b0;
                        cnt_next  = '0;
                        div_next  = '0;
                        lvl_next  = 1'b0;
                    end
                end
            end
        end
    end

    // pin and status levels after the tick
    always_comb begin
        logic bit_out;
        bit_out = cfg.lsb_first ? shift_next[0] : shift_next[top_idx];
        res.sclk_out          = cfg.master_mode & (lvl_next ^ cfg.clock_polarity);
        res.mosi_out          = cfg.master_mode & bit_out;
        res.miso_out          = ~cfg.master_mode & bit_out;
        res.read_word         = rd;
        res.transfer_done     = done_next;
        res.write_collision   = coll_next;
        res.interrupt_request = done_next & cfg.interrupt_enable;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            recv_reg  <= '0;
            cnt_reg   <= '0;
            div_reg   <= '0;
            lvl_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            coll_reg  <= 1'b0;
            swr_reg   <= 1'b0;
            last_reg  <= 1'b0;
            latch_reg <= 1'b0;
        end else begin
            shift_reg <= shift_next;
            recv_reg  <= recv_next;
            cnt_reg   <= cnt_next;
            div_reg   <= div_next;
            lvl_reg   <= lvl_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            coll_reg  <= coll_next;
            swr_reg   <= swr_next;
            last_reg  <= last_next;
            latch_reg <= latch_next;
        end
    end

endmodule

// ===== rtl/spi_controller_master_slave.sv =====
// ----------------------------------------------------------------------------
// spi_controller_master_slave
// SPI controller, master or slave, CPOL/CPHA modes, 8 to MAX_WORD_BITS bits
// per word, stepped once per peripheral clock tick.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    cmd, write_word, line levels
//  m_        out        m_valid / m_ready    pin levels, read_word, flags
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One tick is accepted per cycle while s_ready is high; its result goes to
//  the m_ ports through the input register, then the result register holding
//  the levels. The whole tick is evaluated combinationally between them.
//  A stalled result register holds the input register, and s_ready drops
//  only when both are full. cfg_ready is always high.
//  aresetn is synchronous and clears engine state, config and valid flags.
// ----------------------------------------------------------------------------
module spi_controller_master_slave
    import spi_ctl_pkg::*;
#(
    parameter int MAX_WORD_BITS = DEF_MAX_WORD_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [DATA_W-1:0]  s_write_word,
    input  logic               s_miso_in,
    input  logic               s_mosi_in,
    input  logic               s_sclk_in,
    input  logic               s_select_n_in,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_sclk_out,
    output logic               m_mosi_out,
    output logic               m_miso_out,
    output logic [DATA_W-1:0]  m_read_word,
    output logic               m_transfer_done,
    output logic               m_write_collision,
    output logic               m_interrupt_request
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    logic    out_valid_reg;
    result_t res_comb;
    logic    advance;
    logic    step;
    logic    cfg_wr;
    logic    abort;

    // handshake control
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign advance   = ~out_valid_reg | m_ready;
    assign s_ready   = ~in_valid_reg | advance;
    assign step      = in_valid_reg & advance;

    // a change of mode drops any transfer in progress
    assign abort = cfg_wr && (cfg_index == REG_MASTER_MODE)
                   && (cfg_data[0] != cfg_reg.master_mode);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.master_mode      <= 1'b0;
            cfg_reg.clock_phase      <= 1'b0;
            cfg_reg.clock_polarity   <= 1'b0;
            cfg_reg.lsb_first        <= 1'b0;
            cfg_reg.bits_per_word    <= BPW_RESET;
            cfg_reg.clock_divider    <= DIV_RESET;
            cfg_reg.interrupt_enable <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_MASTER_MODE:      cfg_reg.master_mode      <= cfg_data[0];
                REG_CLOCK_PHASE:      cfg_reg.clock_phase      <= cfg_data[0];
                REG_CLOCK_POLARITY:   cfg_reg.clock_polarity   <= cfg_data[0];
                REG_LSB_FIRST:        cfg_reg.lsb_first        <= cfg_data[0];
                REG_BITS_PER_WORD:    cfg_reg.bits_per_word    <= cfg_data[BPW_W-1:0];
                REG_CLOCK_DIVIDER:    cfg_reg.clock_divider    <= cfg_data;
                REG_INTERRUPT_ENABLE: cfg_reg.interrupt_enable <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.cmd         <= s_cmd;
            item_reg.write_word  <= s_write_word;
            item_reg.miso_in     <= s_miso_in;
            item_reg.mosi_in     <= s_mosi_in;
            item_reg.sclk_in     <= s_sclk_in;
            item_reg.select_n_in <= s_select_n_in;
        end
    end

    // controller core
    spi_ctl_engine #(
        .MAX_WORD_BITS (MAX_WORD_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .abort   (abort),
        .step    (step),
        .item    (item_reg),
        .res     (res_comb)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_comb;
        end
    end

    // result ports
    assign m_valid             = out_valid_reg;
    assign m_sclk_out          = res_reg.sclk_out;
    assign m_mosi_out          = res_reg.mosi_out;
    assign m_miso_out          = res_reg.miso_out;
    assign m_read_word         = res_reg.read_word;
    assign m_transfer_done     = res_reg.transfer_done;
    assign m_write_collision   = res_reg.write_collision;
    assign m_interrupt_request = res_reg.interrupt_request;

endmodule

// ===== test/spi_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_checker
// Watches the configuration, tick and result channels of the SPI controller.
// It keeps its own copy of the shift engine, predicts the pin and status
// levels after every accepted tick and compares each result transfer with
// the oldest prediction.
// ----------------------------------------------------------------------------
module spi_checker
    import spi_ctl_pkg::*;
#(
    parameter int MAX_WORD_BITS = DEF_MAX_WORD_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,

    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [CMD_W-1:0]   s_cmd,
    input  logic [DATA_W-1:0]  s_write_word,
    input  logic               s_miso_in,
    input  logic               s_mosi_in,
    input  logic               s_sclk_in,
    input  logic               s_select_n_in,

    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_sclk_out,
    input  logic               m_mosi_out,
    input  logic               m_miso_out,
    input  logic [DATA_W-1:0]  m_read_word,
    input  logic               m_transfer_done,
    input  logic               m_write_collision,
    input  logic               m_interrupt_request,

    output int                 fail_count,
    output int                 pending
);

    // mirrored registers and engine state
    cfg_t             regs;
    logic [31:0]      shreg;
    logic [31:0]      rxbuf;
    logic [BPW_W-1:0] bits_done;
    logic [DIV_W-1:0] div_cnt;
    logic             sck_phase;
    logic             busy;
    logic             done_flag;
    logic             coll_flag;
    logic             status_armed;
    logic             sclk_prev;
    logic             sampled;

    // predicted levels, oldest first
    result_t          levels_due[$];

    // effective word length
    function automatic int word_len();
        int b = int'(regs.bits_per_word);
        if (b < int'(BPW_MIN)) b = int'(BPW_MIN);
        if (b > MAX_WORD_BITS) b = MAX_WORD_BITS;
        return b;
    endfunction

    function automatic logic [31:0] len_mask(int b);
        return (b >= 32) ? 32'hFFFF_FFFF : ((32'd1 << b) - 32'd1);
    endfunction

    // ticks per serial clock half period
    function automatic int half_div();
        int d = int'(regs.clock_divider);
        if (d < int'(DIV_MIN)) d = int'(DIV_MIN);
        else if (d > int'(DIV_MAX)) d = int'(DIV_MAX);
        d = (d + 1) & ~1;
        return d / 2;
    endfunction

    function automatic void shift_in(int b);
        if (regs.lsb_first) begin
            shreg = (shreg >> 1) | (32'(sampled) << (b - 1));
        end else begin
            shreg = (shreg << 1) | 32'(sampled);
        end
        shreg &= len_mask(b);
    endfunction

    function automatic void stop_xfer();
        busy      = 1'b0;
        bits_done = '0;
        div_cnt   = '0;
        sck_phase = 1'b0;
    endfunction

    function automatic void finish_word(int b);
        rxbuf     = shreg & len_mask(b);
        done_flag = 1'b1;
        stop_xfer();
    endfunction

    // one serial clock edge, leading or trailing
    function automatic void serial_edge(logic leading, logic din, int b);
        if (leading) begin
            if (!regs.clock_phase) sampled = din;
            else if (bits_done != 0) shift_in(b);
        end else if (!regs.clock_phase) begin
            shift_in(b);
            bits_done++;
            if (bits_done >= b) finish_word(b);
        end else begin
            sampled = din;
            bits_done++;
            if (bits_done >= b) begin
                shift_in(b);
                finish_word(b);
            end
        end
    endfunction

    function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
        case (idx)
            REG_MASTER_MODE: begin
                // a change of mode aborts the word in progress
                if (data[0] != regs.master_mode) stop_xfer();
                regs.master_mode = data[0];
            end
            REG_CLOCK_PHASE:      regs.clock_phase      = data[0];
            REG_CLOCK_POLARITY:   regs.clock_polarity   = data[0];
            REG_LSB_FIRST:        regs.lsb_first        = data[0];
            REG_BITS_PER_WORD:    regs.bits_per_word    = data[BPW_W-1:0];
            REG_CLOCK_DIVIDER:    regs.clock_divider    = data;
            REG_INTERRUPT_ENABLE: regs.interrupt_enable = data[0];
            default: ;
        endcase
    endfunction

    // advance the engine by one tick and return the levels after it
    function automatic result_t predict_tick_levels(item_t it);
        int          b;
        logic [31:0] rd;
        logic        ob;
        result_t     r;
        b  = word_len();
        rd = '0;
        // an armed status read clears the flags before the access acts
        if ((it.cmd == CMD_WRITE || it.cmd == CMD_READ) && status_armed) begin
            done_flag    = 1'b0;
            coll_flag    = 1'b0;
            status_armed = 1'b0;
        end
        if (it.cmd == CMD_READ) rd = rxbuf & 32'h0000_FFFF;
        if (it.cmd == CMD_STATUS) status_armed = 1'b1;
        if (it.cmd == CMD_WRITE) begin
            if (busy) begin
                coll_flag = 1'b1;
            end else begin
                shreg = 32'(it.write_word) & len_mask(b);
                if (regs.master_mode) begin
                    stop_xfer();
                    busy = 1'b1;
                end
            end
        end
        // master divides the tick, slave follows the external clock
        if (regs.master_mode) begin
            if (busy) begin
                div_cnt = div_cnt + 8'd1;
                if (div_cnt >= half_div()) begin
                    div_cnt   = '0;
                    sck_phase = ~sck_phase;
                    serial_edge(sck_phase == 1'b1, it.miso_in, b);
                end
            end
        end else if (!it.select_n_in) begin
            if (it.sclk_in != sclk_prev) begin
                busy = 1'b1;
                serial_edge((it.sclk_in ^ regs.clock_polarity) == 1'b1, it.mosi_in, b);
            end
        end else if (busy) begin
            stop_xfer();
        end
        sclk_prev = it.sclk_in;

        ob = regs.lsb_first ? shreg[0] : shreg[b - 1];
        r.sclk_out          = regs.master_mode & (sck_phase ^ regs.clock_polarity);
        r.mosi_out          = regs.master_mode & ob;
        r.miso_out          = !regs.master_mode & ob;
        r.read_word         = rd[DATA_W-1:0];
        r.transfer_done     = done_flag;
        r.write_collision   = coll_flag;
        r.interrupt_request = done_flag & regs.interrupt_enable;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge aclk) begin : watch_channels
        result_t want;
        item_t   it;
        if (!aresetn) begin
            regs.master_mode      = 1'b0;
            regs.clock_phase      = 1'b0;
            regs.clock_polarity   = 1'b0;
            regs.lsb_first        = 1'b0;
            regs.bits_per_word    = BPW_RESET;
            regs.clock_divider    = DIV_RESET;
            regs.interrupt_enable = 1'b0;
            shreg        = '0;
            rxbuf        = '0;
            done_flag    = 1'b0;
            coll_flag    = 1'b0;
            status_armed = 1'b0;
            sclk_prev    = 1'b0;
            sampled      = 1'b0;
            stop_xfer();
            levels_due.delete();
        end else begin
            // result transfer against the oldest prediction
            if (m_valid && m_ready) begin
                if (levels_due.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    fail_count++;
                end else begin
                    want = levels_due.pop_front();
                    check_field("sclk_out", want.sclk_out, m_sclk_out);
                    check_field("mosi_out", want.mosi_out, m_mosi_out);
                    check_field("miso_out", want.miso_out, m_miso_out);
                    check_field("read_word", want.read_word, m_read_word);
                    check_field("transfer_done", want.transfer_done, m_transfer_done);
                    check_field("write_collision", want.write_collision, m_write_collision);
                    check_field("interrupt_request", want.interrupt_request,
                                m_interrupt_request);
                end
            end
            // register write
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            // tick transfer
            if (s_valid && s_ready) begin
                it.cmd         = s_cmd;
                it.write_word  = s_write_word;
                it.miso_in     = s_miso_in;
                it.mosi_in     = s_mosi_in;
                it.sclk_in     = s_sclk_in;
                it.select_n_in = s_select_n_in;
                levels_due.push_back(predict_tick_levels(it));
            end
        end
        pending <= levels_due.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the SPI controller: a short directed run at reset settings,
// then phases of register settings with master words, slave words framed by
// select, broken words and random noise, under random idles on both sides.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import spi_ctl_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 8;
    localparam int MAX_BITS        = DEF_MAX_WORD_BITS;
    localparam int PHASES          = 14;
    localparam int PHASE_TICKS     = 45;
    localparam int PIPE_DEPTH      = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MASTER_TICK_CAP = 200;
    localparam int MAX_IDLE        = 8;

    // indexes with no register behind them
    localparam logic [CIDX_W-1:0] REG_SPARE_LOW  = REG_INTERRUPT_ENABLE + 8'd1;
    localparam logic [CIDX_W-1:0] REG_SPARE_HIGH = 8'hFF;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index;
    logic [CDATA_W-1:0] cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [CMD_W-1:0]   s_cmd;
    logic [DATA_W-1:0]  s_write_word;
    logic               s_miso_in;
    logic               s_mosi_in;
    logic               s_sclk_in;
    logic               s_select_n_in;
    logic               m_valid;
    logic               m_ready;
    logic               m_sclk_out;
    logic               m_mosi_out;
    logic               m_miso_out;
    logic [DATA_W-1:0]  m_read_word;
    logic               m_transfer_done;
    logic               m_write_collision;
    logic               m_interrupt_request;
    int                 fail_count;
    int                 pending;

    // stimulus bookkeeping and settings last written
    bit                 burst_mode;
    int                 ticks_sent;
    int                 idle_cycles;
    logic               cur_master;
    logic               cur_cpol;
    int                 cur_bits;
    int                 cur_half;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    spi_controller_master_slave DUT (.*);

    spi_checker u_checker (.*);

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic item_t mk_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] ww,
                                      logic miso, logic mosi, logic sclk, logic sel_n);
        item_t it;
        it.cmd         = cmd;
        it.write_word  = ww;
        it.miso_in     = miso;
        it.mosi_in     = mosi;
        it.sclk_in     = sclk;
        it.select_n_in = sel_n;
        return it;
    endfunction

    // now and then a bus command lands in the middle of a word
    function automatic item_t maybe_stray(item_t it);
        if ($urandom_range(0, 29) == 0) begin
            it.cmd = CMD_W'($urandom_range(CMD_TICK, CMD_STATUS));
        end
        return it;
    endfunction

    // one tick transfer after a random idle
    task automatic send_tick(item_t it);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= it.cmd;
        s_write_word  <= it.write_word;
        s_miso_in     <= it.miso_in;
        s_mosi_in     <= it.mosi_in;
        s_sclk_in     <= it.sclk_in;
        s_select_n_in <= it.select_n_in;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // wait until every predicted result has arrived and the pipe is empty
    task automatic drain();
        s_valid <= 1'b0;
        repeat (PIPE_DEPTH) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (PIPE_DEPTH) @(posedge aclk);
    endtask

    // write all registers, unused upper data bits random
    task automatic configure(logic m, logic cpha, logic cpol, logic lsb,
                             logic [BPW_W-1:0] bpw, logic [DIV_W-1:0] div, logic ie);
        int d;
        write_reg(REG_MASTER_MODE, {7'($urandom), m});
        write_reg(REG_CLOCK_PHASE, {7'($urandom), cpha});
        write_reg(REG_CLOCK_POLARITY, {7'($urandom), cpol});
        write_reg(REG_LSB_FIRST, {7'($urandom), lsb});
        write_reg(REG_BITS_PER_WORD, {3'($urandom), bpw});
        write_reg(REG_CLOCK_DIVIDER, div);
        write_reg(REG_INTERRUPT_ENABLE, {7'($urandom), ie});
        cfg_valid <= 1'b0;
        cur_master = m;
        cur_cpol   = cpol;
        cur_bits   = (bpw < BPW_MIN) ? int'(BPW_MIN) :
                     (int'(bpw) > MAX_BITS) ? MAX_BITS : int'(bpw);
        d          = (div < DIV_MIN) ? int'(DIV_MIN) :
                     (div > DIV_MAX) ? int'(DIV_MAX) : int'(div);
        cur_half   = ((d + 1) & ~1) / 2;
    endtask

    // mostly legal settings with small dividers, sometimes out of range
    task automatic configure_random();
        logic [7:0] bpw;
        logic [7:0] div;
        int         sel;
        sel = $urandom_range(0, 9);
        bpw = (sel < 7) ? 8'($urandom_range(BPW_MIN, MAX_BITS)) : 8'($urandom_range(0, 31));
        sel = $urandom_range(0, 9);
        if (sel < 7) div = 8'($urandom_range(DIV_MIN, 12));
        else if (sel < 9) div = 8'($urandom_range(0, 255));
        else div = rbit() ? DIV_MAX : DIV_MIN;
        configure(rbit(), rbit(), rbit(), rbit(), bpw[BPW_W-1:0], div, rbit());
    endtask

    // status read, maybe a tick, then the access that clears the flags
    task automatic status_then_access(logic [CMD_W-1:0] access, logic sclk, logic sel_n);
        send_tick(mk_item(CMD_STATUS, 16'($urandom), rbit(), rbit(), sclk, sel_n));
        if ($urandom_range(0, 3) == 0) begin
            send_tick(mk_item(CMD_TICK, 16'($urandom), rbit(), rbit(), sclk, sel_n));
        end
        send_tick(mk_item(access, 16'($urandom), rbit(), rbit(), sclk, sel_n));
    endtask

    // master word: data write, ticks through the word, flag clearing
    task automatic master_word(bit broken);
        int n;
        send_tick(mk_item(CMD_WRITE, 16'($urandom), rbit(), rbit(), rbit(), rbit()));
        n = broken ? $urandom_range(1, 10) : 2 * cur_bits * cur_half + $urandom_range(0, 6);
        if (n > MASTER_TICK_CAP) n = $urandom_range(20, MASTER_TICK_CAP);
        repeat (n) begin
            send_tick(maybe_stray(mk_item(CMD_TICK, 16'($urandom), rbit(), rbit(),
                                          rbit(), rbit())));
        end
        // a broken word ends on a write that may collide
        status_then_access(broken ? CMD_WRITE : (rbit() ? CMD_READ : CMD_WRITE),
                           rbit(), rbit());
    endtask

    // slave word framed by select, released early when broken
    task automatic slave_word(bit broken);
        logic lvl;
        int   edges;
        int   hold;
        lvl = ($urandom_range(0, 7) == 0) ? ~cur_cpol : cur_cpol;
        if (rbit()) begin
            send_tick(mk_item(CMD_WRITE, 16'($urandom), rbit(), rbit(), lvl, 1'b1));
        end
        send_tick(mk_item(CMD_TICK, 16'($urandom), rbit(), rbit(), lvl, 1'b1));
        edges = broken ? $urandom_range(1, 2 * cur_bits - 1) : 2 * cur_bits;
        repeat (edges) begin
            lvl  = ~lvl;
            hold = $urandom_range(1, 3);
            repeat (hold) begin
                send_tick(maybe_stray(mk_item(CMD_TICK, 16'($urandom), rbit(), rbit(),
                                              lvl, 1'b0)));
            end
        end
        send_tick(mk_item(CMD_TICK, 16'($urandom), rbit(), rbit(), lvl, 1'b1));
        status_then_access(rbit() ? CMD_READ : CMD_WRITE, lvl, 1'b1);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 12)) begin
            send_tick(mk_item(CMD_W'($urandom_range(CMD_TICK, CMD_STATUS)), 16'($urandom),
                              rbit(), rbit(), rbit(), rbit()));
        end
    endtask

    // result side stalls at random
    initial begin : result_sink
        int stall;
        m_ready <= 1'b1;
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("spi_controller_master_slave: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic lvl;
        int   phase_end;
        int   pick;
        burst_mode    = 1'b0;
        ticks_sent    = 0;
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_cmd         <= CMD_TICK;
        s_write_word  <= '0;
        s_miso_in     <= 1'b0;
        s_mosi_in     <= 1'b0;
        s_sclk_in     <= 1'b0;
        s_select_n_in <= 1'b1;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: slave mode, 8-bit words, field extremes
        send_tick(mk_item(CMD_TICK, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(mk_item(CMD_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
        // write in slave mode only loads the shift register
        send_tick(mk_item(CMD_WRITE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(mk_item(CMD_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
        // status read alone only arms the clearing
        send_tick(mk_item(CMD_STATUS, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(mk_item(CMD_READ, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(mk_item(CMD_STATUS, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b1));
        send_tick(mk_item(CMD_WRITE, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1));
        // select released in the middle of a word drops it
        lvl = 1'b0;
        for (int e = 0; e < 10; e++) begin
            lvl = ~lvl;
            send_tick(mk_item(CMD_TICK, 16'h5A5A, 1'b0, 1'(e), lvl, 1'b0));
        end
        send_tick(mk_item(CMD_TICK, 16'hA5A5, 1'b0, 1'b0, lvl, 1'b1));
        status_then_access(CMD_READ, lvl, 1'b1);

        // phases of settings, extremes first
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(REG_SPARE_LOW, 8'($urandom));
                    write_reg(REG_SPARE_HIGH, 8'($urandom));
                    configure(1'b1, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0, 1'b1);
                end
                1: configure(1'b1, 1'b1, 1'b1, 1'b1, 5'd31, 8'd255, 1'b0);
                2: configure(1'b0, 1'b0, 1'b0, 1'b0, 5'd16, DIV_MIN, 1'b1);
                3: configure(1'b1, 1'b1, 1'b0, 1'b1, 5'd16, 8'd7, 1'b1);
                4: configure(1'b0, 1'b1, 1'b1, 1'b1, 5'd8, DIV_MAX, 1'b0);
                default: configure_random();
            endcase
            burst_mode = ($urandom_range(0, 3) == 0);
            phase_end  = ticks_sent + PHASE_TICKS;
            while (ticks_sent < phase_end) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    if (cur_master) master_word(1'b0);
                    else slave_word(1'b0);
                end else if (pick < 17) begin
                    if (cur_master) master_word(1'b1);
                    else slave_word(1'b1);
                end else begin
                    noise_burst();
                end
            end
        end

        burst_mode = 1'b0;
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("spi_controller_master_slave: match");
        end else begin
            $display("spi_controller_master_slave: mismatch");
        end
        $finish;
    end

endmodule
